// File: sv/wps_pkg.sv
package wps_pkg;

	localparam int WINDOW_DEF   = 256;
	localparam int CHANNELS_DEF = 8;
	localparam int CH_W         = 3;
	localparam int PRICE_W      = 24;
	localparam int VAR_W        = 48;
	localparam int QUEUE_DEPTH  = 2;
	localparam int OUT_W        = 176;

	typedef enum logic [1:0] {
		F_IDLE,
		F_RD,
		F_UPD
	} front_state_t;

	typedef enum logic [2:0] {
		B_IDLE,
		B_START,
		B_MDIV,
		B_MUL,
		B_VDIV,
		B_SQRT,
		B_OUT
	} back_state_t;

	// bits of the nonzero entry count for a given window
	function automatic int cnt_w(input int window);
		return $clog2(window + 1);
	endfunction

	// packed request: ok, price, sum, square sum, count, min, max
	function automatic int job_w(input int window);
		return 1 + PRICE_W + (PRICE_W + cnt_w(window)) + (2 * PRICE_W + cnt_w(window))
			+ cnt_w(window) + 2 * PRICE_W;
	endfunction

endpackage

// File: sv/windowed_price_statistics_top.sv
// Sliding-window price statistics over up to eight independent channels. A request carries
// the channel in s_axis_tuser and the price (8 fraction bits) in s_axis_tdata; each one gives
// one result with mean, sample variance, deviation, running min and max, the gap to the mean
// and a spread flag. The front takes one request at a time into a two-deep queue and holds
// s_axis_tready low until that request is pushed, which waits while the queue is full. The
// back then takes one request at a time; its run time is set by the bit-serial divider (run
// for the mean, then for the variance) and the bit-pair square root. Requests with fewer than
// two prices skip the variance. The ring store needs no clearing pass after reset: slots a
// channel has not yet reached read as empty.
module windowed_price_statistics_top #(
	parameter int WINDOW   = wps_pkg::WINDOW_DEF,
	parameter int CHANNELS = wps_pkg::CHANNELS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_axis_tvalid,
	output logic                        s_axis_tready,
	// ask_price
	input  logic [wps_pkg::PRICE_W-1:0] s_axis_tdata,
	// channel
	input  logic [wps_pkg::CH_W-1:0]    s_axis_tuser,
	output logic                        m_axis_tvalid,
	input  logic                        m_axis_tready,
	// mean_price, sample_variance, std_deviation, min_price, max_price, mean_gap,
	// spread_valid, zero fill
	output logic [wps_pkg::OUT_W-1:0]   m_axis_tdata
);

	import wps_pkg::*;

	localparam int JW = job_w(WINDOW);

	logic          job_push, job_full, job_pop, job_empty;
	logic [JW-1:0] job_in, job_out;

	wps_front #(
		.WINDOW   (WINDOW),
		.CHANNELS (CHANNELS)
	) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.job_push      (job_push),
		.job_data      (job_in),
		.job_full      (job_full)
	);

	wps_fifo #(
		.WIDTH (JW),
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (job_push),
		.din    (job_in),
		.full   (job_full),
		.pop    (job_pop),
		.dout   (job_out),
		.empty  (job_empty)
	);

	wps_back #(
		.WINDOW (WINDOW)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.job_valid     (!job_empty),
		.job_data      (job_out),
		.job_pop       (job_pop),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

`ifndef SYNTHESIS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(job_push && job_full))
		else $error("queue written while full");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(job_pop && job_empty))
		else $error("queue read while empty");

	a_no_spread: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tdata[168] |-> m_axis_tdata[95:24] == '0)
		else $error("variance without two prices");
`endif

endmodule

// File: sv/wps_ram.sv
module wps_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 2048
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// File: sv/wps_fifo.sv
module wps_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] din,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] dout,
	output logic             empty
);

	localparam int PTRW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNTW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTRW-1:0]  wr_q;
	logic [PTRW-1:0]  rd_q;
	logic [CNTW-1:0]  cnt_q;

	assign full  = (cnt_q == CNTW'(DEPTH));
	assign empty = (cnt_q == '0);
	assign dout  = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PTRW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == PTRW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

// File: sv/wps_front.sv
module wps_front #(
	parameter int WINDOW   = wps_pkg::WINDOW_DEF,
	parameter int CHANNELS = wps_pkg::CHANNELS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	input  logic [wps_pkg::PRICE_W-1:0]         s_axis_tdata,
	input  logic [wps_pkg::CH_W-1:0]            s_axis_tuser,
	output logic                                job_push,
	output logic [wps_pkg::job_w(WINDOW)-1:0]   job_data,
	input  logic                                job_full
);

	import wps_pkg::*;

	localparam int CW   = cnt_w(WINDOW);
	localparam int SUMW = PRICE_W + CW;
	localparam int SQW  = 2 * PRICE_W + CW;
	localparam int PW   = $clog2(WINDOW);
	localparam int CHW  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int RAMD = CHANNELS * (2 ** PW);
	localparam int AW   = $clog2(RAMD);

	front_state_t state_q, state_d;

	logic [PW-1:0]        ptr_q  [CHANNELS];
	logic                 wrap_q [CHANNELS];
	logic [SUMW-1:0]      sum_q  [CHANNELS];
	logic [SQW-1:0]       sq_q   [CHANNELS];
	logic [CW-1:0]        cnt_q  [CHANNELS];
	logic [PRICE_W-1:0]   min_q  [CHANNELS];
	logic [PRICE_W-1:0]   max_q  [CHANNELS];

	logic [CHW-1:0]       chi_in;
	logic                 inr_in;
	logic [PW-1:0]        ptr_in;
	logic                 take;

	logic [CHW-1:0]       chi_s1;
	logic                 inr_s1;
	logic [PRICE_W-1:0]   ask_s1;
	logic [2*PRICE_W-1:0] asq_s1;
	logic [PW-1:0]        ptr_s1;
	logic [AW-1:0]        addr_s1;
	logic [PRICE_W-1:0]   old_s2;
	logic [2*PRICE_W-1:0] osq_s2;

	logic [PRICE_W-1:0]   rd_data;
	logic [PRICE_W-1:0]   old_val;
	logic                 upd;

	logic [SUMW-1:0]      sum_cur, sum_new;
	logic [SQW-1:0]       sq_cur, sq_new;
	logic [CW-1:0]        cnt_cur, cnt_new;
	logic [PRICE_W-1:0]   min_cur, min_new, max_cur, max_new;
	logic                 wrap_cur;
	logic [PW-1:0]        ptr_nxt;

	assign chi_in = CHW'(s_axis_tuser);
	assign inr_in = ({1'b0, s_axis_tuser} < (CH_W + 1)'(CHANNELS));
	assign ptr_in = inr_in ? ptr_q[chi_in] : '0;
	assign take   = s_axis_tvalid && s_axis_tready;

	wps_ram #(
		.WIDTH (PRICE_W),
		.DEPTH (RAMD)
	) u_ring (
		.clk   (clk),
		.we    (upd && inr_s1),
		.waddr (addr_s1),
		.wdata (ask_s1),
		.raddr (AW'({chi_in, ptr_in})),
		.rdata (rd_data)
	);

	// slots not yet reached since reset read as empty
	assign wrap_cur = inr_s1 ? wrap_q[chi_s1] : 1'b0;
	assign old_val  = wrap_cur ? rd_data : '0;
	assign sum_cur  = inr_s1 ? sum_q[chi_s1] : '0;
	assign sq_cur   = inr_s1 ? sq_q[chi_s1]  : '0;
	assign cnt_cur  = inr_s1 ? cnt_q[chi_s1] : '0;
	assign min_cur  = inr_s1 ? min_q[chi_s1] : '0;
	assign max_cur  = inr_s1 ? max_q[chi_s1] : '0;

	assign sum_new = sum_cur - SUMW'(old_s2) + SUMW'(ask_s1);
	assign sq_new  = sq_cur - SQW'(osq_s2) + SQW'(asq_s1);
	assign cnt_new = cnt_cur - CW'(old_s2 != '0) + CW'(ask_s1 != '0);
	assign max_new = (ask_s1 > max_cur) ? ask_s1 : max_cur;
	assign min_new = ((ask_s1 < min_cur) || (min_cur == '0)) ? ask_s1 : min_cur;
	assign ptr_nxt = (ptr_s1 == PW'(WINDOW - 1)) ? '0 : ptr_s1 + 1'b1;

	assign job_data = {inr_s1, ask_s1, sum_new, sq_new, cnt_new, min_new, max_new};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d       = state_q;
		s_axis_tready = 1'b0;
		job_push      = 1'b0;
		upd           = 1'b0;
		unique case (state_q)
			F_IDLE: begin
				s_axis_tready = 1'b1;
				if (s_axis_tvalid) begin
					state_d = F_RD;
				end
			end
			F_RD: begin
				state_d = F_UPD;
			end
			F_UPD: begin
				if (!job_full) begin
					job_push = 1'b1;
					upd      = 1'b1;
					state_d  = F_IDLE;
				end
			end
			default: state_d = F_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (take) begin
			chi_s1  <= chi_in;
			inr_s1  <= inr_in;
			ask_s1  <= s_axis_tdata;
			asq_s1  <= s_axis_tdata * s_axis_tdata;
			ptr_s1  <= ptr_in;
			addr_s1 <= AW'({chi_in, ptr_in});
		end
		if (state_q == F_RD) begin
			old_s2 <= old_val;
			osq_s2 <= old_val * old_val;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < CHANNELS; c++) begin
				ptr_q[c]  <= '0;
				wrap_q[c] <= 1'b0;
				sum_q[c]  <= '0;
				sq_q[c]   <= '0;
				cnt_q[c]  <= '0;
				min_q[c]  <= '0;
				max_q[c]  <= '0;
			end
		end else if (upd && inr_s1) begin
			ptr_q[chi_s1] <= ptr_nxt;
			if (ptr_nxt == '0) begin
				wrap_q[chi_s1] <= 1'b1;
			end
			sum_q[chi_s1] <= sum_new;
			sq_q[chi_s1]  <= sq_new;
			cnt_q[chi_s1] <= cnt_new;
			min_q[chi_s1] <= min_new;
			max_q[chi_s1] <= max_new;
		end
	end

endmodule

// File: sv/wps_back.sv
module wps_back #(
	parameter int WINDOW = wps_pkg::WINDOW_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              job_valid,
	input  logic [wps_pkg::job_w(WINDOW)-1:0] job_data,
	output logic                              job_pop,
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	output logic [wps_pkg::OUT_W-1:0]         m_axis_tdata
);

	import wps_pkg::*;

	localparam int CW   = cnt_w(WINDOW);
	localparam int SUMW = PRICE_W + CW;
	localparam int SQW  = 2 * PRICE_W + CW;
	localparam int NUMW = SQW + CW;
	localparam int SQL  = (SQW + 1) / 2;
	localparam int SL   = (SUMW + 1) / 2;
	localparam int DIVW = 2 * CW;
	localparam int KW   = $clog2(NUMW + 1);
	localparam int SHW  = $clog2(NUMW);
	localparam int PAD  = OUT_W - (5 * PRICE_W + VAR_W + 1);

	back_state_t state_q, state_d;

	logic                 j_ok;
	logic [PRICE_W-1:0]   j_ask, j_min, j_max;
	logic [SUMW-1:0]      j_sum;
	logic [SQW-1:0]       j_sq;
	logic [CW-1:0]        j_n;

	logic                 ok_q;
	logic [PRICE_W-1:0]   ask_q, min_q, max_q;
	logic [SUMW-1:0]      sum_q;
	logic [SQW-1:0]       sq_q;
	logic [CW-1:0]        n_q;

	logic [PRICE_W-1:0]   mean_q, sd_q;
	logic [VAR_W-1:0]     var_q;

	logic [NUMW-1:0]      dvd_q;
	logic [DIVW-1:0]      dsr_q;
	logic [DIVW-1:0]      rem_q;
	logic [VAR_W-1:0]     quo_q;
	logic [KW-1:0]        cnt_q;
	logic [DIVW:0]        r2;
	logic                 ge;

	logic [2:0]           mstep_q;
	logic [NUMW-1:0]      acc_q, prod_q;
	logic                 sub_q;
	logic [SQL-1:0]       ma, mb;
	logic [2*SQL-1:0]     pm;
	logic [SHW-1:0]       sh;
	logic                 msub;

	logic [VAR_W-1:0]     v_q, res_q, bit_q, sqt;

	logic [PRICE_W-1:0]   gap;
	logic                 spread;
	logic                 out_load;

	assign {j_ok, j_ask, j_sum, j_sq, j_n, j_min, j_max} = job_data;

	// restoring divider, one quotient bit a cycle
	assign r2 = {rem_q, dvd_q[NUMW-1]};
	assign ge = (r2 >= {1'b0, dsr_q});

	// shared multiplier for the variance numerator and n*(n-1)
	always_comb begin
		ma   = SQL'(n_q);
		mb   = '0;
		sh   = '0;
		msub = 1'b0;
		case (mstep_q)
			3'd0: mb = sq_q[SQL-1:0];
			3'd1: begin
				mb = SQL'(sq_q[SQW-1:SQL]);
				sh = SHW'(SQL);
			end
			3'd2: begin
				ma   = SQL'(sum_q[SL-1:0]);
				mb   = SQL'(sum_q[SL-1:0]);
				msub = 1'b1;
			end
			3'd3: begin
				ma   = SQL'(sum_q[SL-1:0]);
				mb   = SQL'(sum_q[SUMW-1:SL]);
				sh   = SHW'(SL + 1);
				msub = 1'b1;
			end
			3'd4: begin
				ma   = SQL'(sum_q[SUMW-1:SL]);
				mb   = SQL'(sum_q[SUMW-1:SL]);
				sh   = SHW'(2 * SL);
				msub = 1'b1;
			end
			3'd5: mb = SQL'(n_q - 1'b1);
			default: ma = '0;
		endcase
	end

	assign pm  = ma * mb;
	assign sqt = res_q + bit_q;

	assign gap    = (ask_q >= mean_q) ? ask_q - mean_q : mean_q - ask_q;
	assign spread = (n_q > CW'(1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		job_pop  = 1'b0;
		out_load = 1'b0;
		unique case (state_q)
			B_IDLE: begin
				if (job_valid) begin
					job_pop = 1'b1;
					state_d = B_START;
				end
			end
			B_START: begin
				state_d = (!ok_q || n_q == '0) ? B_OUT : B_MDIV;
			end
			B_MDIV: begin
				if (cnt_q == '0) begin
					state_d = spread ? B_MUL : B_OUT;
				end
			end
			B_MUL: begin
				if (mstep_q == 3'd6) begin
					state_d = B_VDIV;
				end
			end
			B_VDIV: begin
				if (cnt_q == '0) begin
					state_d = B_SQRT;
				end
			end
			B_SQRT: begin
				if (bit_q == '0) begin
					state_d = B_OUT;
				end
			end
			B_OUT: begin
				if (!m_axis_tvalid || m_axis_tready) begin
					out_load = 1'b1;
					state_d  = B_IDLE;
				end
			end
			default: state_d = B_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (job_pop) begin
			ok_q  <= j_ok;
			ask_q <= j_ask;
			sum_q <= j_sum;
			sq_q  <= j_sq;
			n_q   <= j_n;
			min_q <= j_min;
			max_q <= j_max;
		end
		case (state_q) inside
			B_START: begin
				mean_q <= '0;
				var_q  <= '0;
				sd_q   <= '0;
				dvd_q  <= NUMW'(sum_q) << (NUMW - SUMW);
				dsr_q  <= DIVW'(n_q);
				rem_q  <= '0;
				quo_q  <= '0;
				cnt_q  <= KW'(SUMW);
			end
			B_MDIV, B_VDIV: begin
				if (cnt_q != '0) begin
					rem_q <= ge ? DIVW'(r2 - {1'b0, dsr_q}) : r2[DIVW-1:0];
					quo_q <= {quo_q[VAR_W-2:0], ge};
					dvd_q <= dvd_q << 1;
					cnt_q <= cnt_q - 1'b1;
				end else if (state_q == B_MDIV) begin
					mean_q  <= quo_q[PRICE_W-1:0];
					mstep_q <= '0;
					acc_q   <= '0;
				end else begin
					var_q <= quo_q;
					v_q   <= quo_q;
					res_q <= '0;
					bit_q <= VAR_W'(1) << (VAR_W - 2);
				end
			end
			B_MUL: begin
				mstep_q <= mstep_q + 1'b1;
				prod_q  <= NUMW'(pm) << sh;
				sub_q   <= msub;
				if (mstep_q >= 3'd1 && mstep_q <= 3'd5) begin
					acc_q <= sub_q ? acc_q - prod_q : acc_q + prod_q;
				end
				if (mstep_q == 3'd6) begin
					dsr_q <= prod_q[DIVW-1:0];
					dvd_q <= acc_q;
					rem_q <= '0;
					quo_q <= '0;
					cnt_q <= KW'(NUMW);
				end
			end
			B_SQRT: begin
				if (bit_q != '0) begin
					if (v_q >= sqt) begin
						v_q   <= v_q - sqt;
						res_q <= (res_q >> 1) + bit_q;
					end else begin
						res_q <= res_q >> 1;
					end
					bit_q <= bit_q >> 2;
				end else begin
					sd_q <= res_q[PRICE_W-1:0];
				end
			end
			default: ;
		endcase
		if (out_load) begin
			if (ok_q) begin
				m_axis_tdata <= {PAD'(0), spread && n_q != '0, gap, max_q, min_q, sd_q, var_q,
					mean_q};
			end else begin
				m_axis_tdata <= '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tvalid <= 1'b0;
		end else if (out_load) begin
			m_axis_tvalid <= 1'b1;
		end else if (m_axis_tready) begin
			m_axis_tvalid <= 1'b0;
		end
	end

endmodule
